// File: rtl/core/ffca_pkg.sv
// ----------------------------------------------------------------------------
// First-fit allocator package
// Field widths, status codes, request kinds and the result record shared by
// the allocator core and its checker.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int NAME_W      = 64;
  localparam int CNT_W       = 9;
  localparam int START_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = 9'd256;

  // Request kinds carried on s_tuser.
  localparam logic REQ_CREATE = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Result status codes carried on m_tuser.
  localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIR_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  first_blk;
    logic [CNT_W-1:0]    extent_length;
  } res_t;

endpackage

// File: rtl/core/first_fit_contiguous_allocator_core.sv
// A create scans at most min(total_blocks, MAX_BLOCKS) bitmap bits and then marks
// block_count bits in a marking pass through one RAM write port.
// A delete runs the directory search over the entry_count entries, the freeing pass
// over extent_length bits and the compaction that moves every later entry down one slot.
// One transaction is in work at a time; a new one is taken while a result still waits.
// After reset the bitmap RAM is cleared with s_tready low.
// ----------------------------------------------------------------------------
// First-fit contiguous allocator core
// Keeps a used-block bitmap and a named extent directory in two RAMs and
// serves create and delete requests with a first-fit search.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator_core #(
  parameter int MAX_BLOCKS  = 256,
  parameter int MAX_ENTRIES = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ffca_pkg::CNT_W-1:0]       cfg_wdata,   // total_blocks
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ffca_pkg::IN_TDATA_W-1:0]  s_tdata,     // name_key[63:0], block_count[72:64]
  input  logic                             s_tuser,     // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ffca_pkg::OUT_TDATA_W-1:0] m_tdata,     // first_blk[7:0], extent_length[16:8]
  output logic [ffca_pkg::STATUS_W-1:0]    m_tuser      // status
);

  import ffca_pkg::*;

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int LW = (SW + 1 > CNT_W) ? SW + 1 : CNT_W;
  localparam int DW = NAME_W + SW + CNT_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_C_SCAN,
    S_C_MARK,
    S_C_APPEND,
    S_D_SCAN,
    S_D_FREE,
    S_D_SHIFT,
    S_OUT
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  total_blocks;
  logic [NAME_W-1:0] req_name;
  logic [CNT_W-1:0]  req_cnt;
  logic [SW:0]       blk_idx;
  logic [SW-1:0]     blk_rd;
  logic [EW:0]       ent_idx;
  logic [EW-1:0]     ent_rd;
  logic [EW:0]       entry_count;
  logic              rd_pend;
  logic [LW-1:0]     run;
  logic [SW-1:0]     ext_start;
  logic [CNT_W-1:0]  ext_len;
  logic [CNT_W-1:0]  step;
  res_t              res;

  logic              bm_we;
  logic [SW-1:0]     bm_waddr;
  logic              bm_wdata;
  logic              bm_rdata;
  logic              dir_we;
  logic [EW-1:0]     dir_waddr;
  logic [DW-1:0]     dir_wdata;
  logic [DW-1:0]     dir_rdata;

  logic [LW-1:0]     limit;
  logic [LW-1:0]     cnt_ext;
  logic [LW-1:0]     run_next;
  logic [LW:0]       blk_sum;
  logic              blk_issue;
  logic              ent_issue;
  logic              name_hit;

  ffca_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (blk_idx[SW-1:0]),
    .rdata (bm_rdata)
  );

  ffca_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (ent_idx[EW-1:0]),
    .rdata (dir_rdata)
  );

  assign s_tready = (state == S_IDLE);

  // Blocks beyond the bitmap depth are never scanned.
  assign limit = (LW'(total_blocks) > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : LW'(total_blocks);
  assign cnt_ext   = LW'(req_cnt);
  assign run_next  = bm_rdata ? '0 : run + LW'(1);
  assign blk_sum   = (LW + 1)'(ext_start) + (LW + 1)'(step);
  assign blk_issue = (LW'(blk_idx) < limit);
  assign ent_issue = (ent_idx < entry_count);
  assign name_hit  = (dir_rdata[DW-1 -: NAME_W] == req_name);

  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = blk_sum[SW-1:0];
    bm_wdata  = 1'b0;
    dir_we    = 1'b0;
    dir_waddr = entry_count[EW-1:0];
    dir_wdata = {req_name, ext_start, req_cnt};
    unique case (state)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = blk_idx[SW-1:0];
      end
      S_C_MARK: begin
        bm_we    = 1'b1;
        bm_wdata = 1'b1;
      end
      S_D_FREE: begin
        bm_we = (blk_sum < (LW + 1)'(MAX_BLOCKS));
      end
      S_C_APPEND: begin
        dir_we = 1'b1;
      end
      S_D_SHIFT: begin
        // Each entry read behind the removed one lands one slot lower.
        dir_we    = rd_pend;
        dir_waddr = ent_rd - EW'(1);
        dir_wdata = dir_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      total_blocks <= TOTAL_BLOCKS_RST;
      blk_idx      <= '0;
      ent_idx      <= '0;
      entry_count  <= '0;
      rd_pend      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_blocks <= cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_pend <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          blk_idx <= blk_idx + (SW + 1)'(1);
          if (blk_idx == (SW + 1)'(MAX_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (s_tvalid) begin
            req_name <= s_tdata[NAME_W-1:0];
            req_cnt  <= s_tdata[NAME_W +: CNT_W];
            blk_idx  <= '0;
            ent_idx  <= '0;
            run      <= '0;
            step     <= '0;
            if (s_tuser == REQ_DELETE) begin
              state <= S_D_SCAN;
            end else if (entry_count == (EW + 1)'(MAX_ENTRIES)) begin
              res   <= '{ST_DIR_FULL, '0, '0};
              state <= S_OUT;
            end else if (s_tdata[NAME_W +: CNT_W] == '0) begin
              ext_start <= '0;
              state     <= S_C_APPEND;
            end else if (LW'(s_tdata[NAME_W +: CNT_W]) > limit) begin
              res   <= '{ST_NO_SPACE, '0, '0};
              state <= S_OUT;
            end else begin
              state <= S_C_SCAN;
            end
          end
        end

        S_C_SCAN: begin
          // Reads are issued one per cycle; the run length is updated in the next
          // cycle, when the bit comes back.
          if (blk_issue) begin
            rd_pend <= 1'b1;
            blk_rd  <= blk_idx[SW-1:0];
            blk_idx <= blk_idx + (SW + 1)'(1);
          end
          if (rd_pend) begin
            run <= run_next;
            if (run_next >= cnt_ext) begin
              ext_start <= SW'(LW'(blk_rd) + LW'(1) - cnt_ext);
              step      <= '0;
              state     <= S_C_MARK;
            end
          end else if (!blk_issue) begin
            res   <= '{ST_NO_SPACE, '0, '0};
            state <= S_OUT;
          end
        end

        S_C_MARK: begin
          step <= step + CNT_W'(1);
          if (step == req_cnt - CNT_W'(1)) begin
            state <= S_C_APPEND;
          end
        end

        S_C_APPEND: begin
          entry_count <= entry_count + (EW + 1)'(1);
          res         <= '{ST_CREATED, START_W'(ext_start), req_cnt};
          state       <= S_OUT;
        end

        S_D_SCAN: begin
          if (ent_issue) begin
            rd_pend <= 1'b1;
            ent_rd  <= ent_idx[EW-1:0];
            ent_idx <= ent_idx + (EW + 1)'(1);
          end
          if (rd_pend && name_hit) begin
            ext_start <= dir_rdata[CNT_W +: SW];
            ext_len   <= dir_rdata[CNT_W-1:0];
            step      <= '0;
            rd_pend   <= 1'b0;
            ent_idx   <= (EW + 1)'(ent_rd) + (EW + 1)'(1);
            state     <= (dir_rdata[CNT_W-1:0] == '0) ? S_D_SHIFT : S_D_FREE;
          end else if (!rd_pend && !ent_issue) begin
            res   <= '{ST_NOT_FOUND, '0, '0};
            state <= S_OUT;
          end
        end

        S_D_FREE: begin
          step <= step + CNT_W'(1);
          if (step == ext_len - CNT_W'(1)) begin
            state <= S_D_SHIFT;
          end
        end

        S_D_SHIFT: begin
          if (ent_issue) begin
            rd_pend <= 1'b1;
            ent_rd  <= ent_idx[EW-1:0];
            ent_idx <= ent_idx + (EW + 1)'(1);
          end
          if (!rd_pend && !ent_issue) begin
            entry_count <= entry_count - (EW + 1)'(1);
            res         <= '{ST_DELETED, START_W'(ext_start), ext_len};
            state       <= S_OUT;
          end
        end

        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res.status;
            m_tdata  <= OUT_TDATA_W'({res.extent_length, res.first_blk});
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/ffca_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ffca_checker.sv
// ----------------------------------------------------------------------------
// First-fit allocator port checker
// Watches the ports of the allocator core for result and handshake rules.
// ----------------------------------------------------------------------------
module ffca_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ffca_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [ffca_pkg::STATUS_W-1:0]    m_tuser
);

  import ffca_pkg::*;

  // Only the defined status codes may leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_CREATED || m_tuser == ST_NO_SPACE ||
                  m_tuser == ST_DIR_FULL || m_tuser == ST_DELETED ||
                  m_tuser == ST_NOT_FOUND))
    else $error("undefined status code on result");

  // Every error result carries a zero start and a zero length.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_NO_SPACE || m_tuser == ST_DIR_FULL ||
                  m_tuser == ST_NOT_FOUND)) |-> (m_tdata == '0))
    else $error("error result with nonzero extent");

  // The bitmap clearing pass follows reset, so nothing is taken or shown.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s_tready))
    else $error("block active right after reset");

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind first_fit_contiguous_allocator_core ffca_checker u_ffca_checker (.*);

// File: verif/extent_result_checker.sv
// ----------------------------------------------------------------------------
// Extent result checker
// Watches the configuration port and both stream channels of the allocator.
// It keeps its own copy of the block bitmap and the extent directory, so it
// can work out the result of every accepted request. Each accepted result is
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module extent_result_checker #(
  parameter int MAX_BLOCKS  = 256,
  parameter int MAX_ENTRIES = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ffca_pkg::CNT_W-1:0]       cfg_wdata,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [ffca_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ffca_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic [ffca_pkg::STATUS_W-1:0]    m_tuser,
  output int                               mismatch_count,
  output int                               results_outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import ffca_pkg::*;

  bit                 block_used [MAX_BLOCKS];
  logic [NAME_W-1:0]  dir_name   [MAX_ENTRIES];
  logic [START_W-1:0] dir_start  [MAX_ENTRIES];
  logic [CNT_W-1:0]   dir_len    [MAX_ENTRIES];
  int                 dir_count = 0;
  logic [CNT_W-1:0]   total_blocks = TOTAL_BLOCKS_RST;
  res_t               expected_results [$];
  int                 fail_total = 0;
  int                 waiting_total = 0;

  assign mismatch_count      = fail_total;
  assign results_outstanding = waiting_total;

  // First-fit search below the usable block count, then mark and append.
  function automatic res_t alloc_extent(input logic [NAME_W-1:0] name,
                                        input logic [CNT_W-1:0] cnt);
    int   lim;
    int   run;
    int   first;
    bit   found;
    res_t r;
    r = '0;
    lim = (int'(total_blocks) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_blocks);
    if (dir_count >= MAX_ENTRIES) begin
      r.status = ST_DIR_FULL;
      return r;
    end
    run   = 0;
    first = 0;
    found = (cnt == '0);
    if (!found && int'(cnt) <= lim) begin
      for (int i = 0; i < lim && !found; i++) begin
        run = block_used[i] ? 0 : run + 1;
        if (run >= int'(cnt)) begin
          first = i + 1 - int'(cnt);
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      r.status = ST_NO_SPACE;
      return r;
    end
    for (int i = 0; i < int'(cnt); i++) block_used[first + i] = 1'b1;
    dir_name[dir_count]  = name;
    dir_start[dir_count] = first[START_W-1:0];
    dir_len[dir_count]   = cnt;
    dir_count++;
    r.status        = ST_CREATED;
    r.first_blk     = first[START_W-1:0];
    r.extent_length = cnt;
    return r;
  endfunction

  // Frees the oldest entry with a matching name and closes the gap behind it.
  function automatic res_t free_extent(input logic [NAME_W-1:0] name);
    int   idx;
    res_t r;
    r   = '0;
    idx = -1;
    for (int i = 0; i < dir_count; i++) begin
      if (idx < 0 && dir_name[i] == name) idx = i;
    end
    if (idx < 0) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    for (int i = 0; i < int'(dir_len[idx]); i++) begin
      if (int'(dir_start[idx]) + i < MAX_BLOCKS) block_used[int'(dir_start[idx]) + i] = 1'b0;
    end
    r.status        = ST_DELETED;
    r.first_blk     = dir_start[idx];
    r.extent_length = dir_len[idx];
    for (int i = idx; i + 1 < dir_count; i++) begin
      dir_name[i]  = dir_name[i + 1];
      dir_start[i] = dir_start[i + 1];
      dir_len[i]   = dir_len[i + 1];
    end
    dir_count--;
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (block_used[i]) block_used[i] = 1'b0;
      dir_count    = 0;
      total_blocks = TOTAL_BLOCKS_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) total_blocks = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: status %0d start %0d length %0d",
                   $time, m_tuser, m_tdata[7:0], m_tdata[16:8]);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", CNT_W'(want.status), CNT_W'(m_tuser));
          check_field("first_blk", CNT_W'(want.first_blk), CNT_W'(m_tdata[7:0]));
          check_field("extent_length", want.extent_length, m_tdata[16:8]);
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_CREATE)
          expected_results.push_back(alloc_extent(s_tdata[NAME_W-1:0],
                                                  s_tdata[NAME_W+CNT_W-1:NAME_W]));
        else
          expected_results.push_back(free_extent(s_tdata[NAME_W-1:0]));
      end
    end
    waiting_total = expected_results.size();
  end

endmodule

// File: verif/tb_first_fit_contiguous_allocator_core.sv
// ----------------------------------------------------------------------------
// First-fit allocator core testbench
// Drives create and delete requests into the allocator, first a directed set
// around the corner cases, then random phases under different block counts
// and idle patterns. The checker beside the core predicts and compares every
// result; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_first_fit_contiguous_allocator_core;

  timeunit 1ns;
  timeprecision 1ps;

  import ffca_pkg::*;

  localparam int MAX_BLOCKS      = 256;
  localparam int MAX_ENTRIES     = 128;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 146;
  localparam int DRAIN_CYCLES    = 600;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = REQ_CREATE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;

  int                mismatch_count;
  int                results_outstanding;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int unsigned       cycle_count = 0;
  logic [NAME_W-1:0] live_names [$];

  int phase_total  [PHASES] = '{256, 13, 400, 1, 64, 256, 2, 200};
  int phase_create [PHASES] = '{70, 60, 95, 90, 30, 70, 55, 50};

  first_fit_contiguous_allocator_core #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  extent_result_checker #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tuser            (s_tuser),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tuser            (m_tuser),
    .mismatch_count     (mismatch_count),
    .results_outstanding(results_outstanding)
  );

  initial begin
    forever #1ns clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL first_fit_contiguous_allocator_core");
      $finish;
    end
  end

  // This task lowers the valid only while idling, so back-to-back requests keep it high.
  task automatic send_req(input logic kind, input logic [NAME_W-1:0] name,
                          input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_TDATA_W-NAME_W-CNT_W){1'b0}}, cnt, name};
    do @(posedge clk); while (!s_tready);
  endtask

  // The first wait lets the checker count a transaction accepted at this edge.
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
  endtask

  task automatic write_total_blocks(input logic [CNT_W-1:0] value);
    wait_all_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [NAME_W-1:0] random_name();
    if ($urandom_range(99) < 25)
      return 64'hC0DE_0000_0000_0000 | NAME_W'($urandom_range(7));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CNT_W-1:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return CNT_W'($urandom_range(3));
    if (pick < 80) return CNT_W'($urandom_range(12));
    if (pick < 95) return CNT_W'($urandom_range(48));
    return CNT_W'($urandom_range(MAX_BLOCKS));
  endfunction

  // Deletes mostly target names that were created earlier, so the directory
  // both fills up and drains; the rest use random names.
  task automatic random_req(input int create_pct);
    logic [NAME_W-1:0] name;
    int                idx;
    if ($urandom_range(99) < create_pct) begin
      name = random_name();
      live_names.push_back(name);
      send_req(REQ_CREATE, name, random_count());
    end else begin
      if (live_names.size() > 0 && $urandom_range(99) < 85) begin
        idx  = $urandom_range(live_names.size() - 1);
        name = live_names[idx];
        live_names.delete(idx);
      end else begin
        name = random_name();
      end
      send_req(REQ_DELETE, name, CNT_W'($urandom_range(511)));
    end
  endtask

  task automatic run_directed();
    logic [NAME_W-1:0] name_zero;
    logic [NAME_W-1:0] name_ones;
    logic [NAME_W-1:0] name_dup;
    logic [NAME_W-1:0] name_big;
    name_zero = '0;
    name_ones = '1;
    name_dup  = 64'h5555_5555_5555_5555;
    name_big  = 64'h8000_0000_0000_0001;
    send_req(REQ_CREATE, name_zero, 9'd0);
    send_req(REQ_CREATE, name_big, 9'd256);
    send_req(REQ_CREATE, name_ones, 9'd1);
    send_req(REQ_DELETE, name_big, 9'd0);
    send_req(REQ_CREATE, name_ones, 9'd1);
    send_req(REQ_CREATE, name_dup, 9'd3);
    send_req(REQ_CREATE, name_dup, 9'd2);
    // Only the older of the two duplicate entries goes away.
    send_req(REQ_DELETE, name_dup, 9'd511);
    send_req(REQ_CREATE, 64'hAAAA_AAAA_AAAA_AAAA, 9'd2);
    send_req(REQ_DELETE, name_zero, 9'd0);
    send_req(REQ_DELETE, name_zero, 9'd0);
    // A shrunk disk: the remaining duplicate lies above the usable range.
    write_total_blocks(9'd4);
    send_req(REQ_CREATE, 64'h0000_0000_0000_0005, 9'd5);
    send_req(REQ_CREATE, 64'h0000_0000_0000_0006, 9'd2);
    send_req(REQ_CREATE, 64'h0000_0000_0000_0007, 9'd1);
    send_req(REQ_DELETE, name_dup, 9'd0);
    write_total_blocks(9'd0);
    send_req(REQ_CREATE, 64'h0000_0000_0000_0008, 9'd0);
    send_req(REQ_CREATE, 64'h0000_0000_0000_0009, 9'd1);
    // Values above the bitmap depth saturate to the full disk.
    write_total_blocks(9'd511);
    send_req(REQ_CREATE, 64'h0000_0000_0000_000A, 9'd256);
    send_req(REQ_CREATE, 64'h0000_0000_0000_000B, 9'd100);
    write_total_blocks(9'd300);
    send_req(REQ_CREATE, 64'h0000_0000_0000_000C, 9'd256);
    send_req(REQ_CREATE, 64'h0000_0000_0000_000D, 9'd150);
    send_req(REQ_DELETE, name_ones, 9'd0);
    send_req(REQ_DELETE, 64'h1234_5678_9ABC_DEF0, 9'd0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_total_blocks(TOTAL_BLOCKS_RST);
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      write_total_blocks(CNT_W'(phase_total[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (send_idle_pct == 0 && k % 40 == 39) wait_all_results();
        random_req(phase_create[ph]);
      end
    end
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("PASS first_fit_contiguous_allocator_core");
    end else begin
      $display("FAIL first_fit_contiguous_allocator_core");
    end
    $finish;
  end

endmodule
